FILE: rtl/core/srtp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtp_pkg: shared types and constants for the subtitle time-range parser
// Holds the timestamp pattern table, digit weights and the result record.
// ----------------------------------------------------------------------------
package srtp_pkg;

  localparam int BYTE_W     = 8;
  localparam int MS_W       = 29;
  localparam int POS_W      = 4;
  localparam int COUNT_W    = 2;
  localparam int WEIGHT_W   = 26;
  localparam int DIGIT_W    = 4;

  localparam logic [POS_W-1:0] PATTERN_LEN = 4'd12;
  localparam logic [POS_W-1:0] POS_LAST    = 4'd11;

  // Pattern codes: ANY_DIGIT stands for any of '0'..'9'.
  localparam logic [BYTE_W-1:0] ANY_DIGIT  = 8'h00;
  localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

  localparam logic [COUNT_W-1:0] MATCH_NONE  = 2'd0;
  localparam logic [COUNT_W-1:0] MATCH_START = 2'd1;
  localparam logic [COUNT_W-1:0] MATCH_BOTH  = 2'd2;

  typedef struct packed {
    logic            both_found;
    logic            first_found;
    logic [MS_W-1:0] start_ms;
    logic [MS_W-1:0] end_ms;
  } result_t;

  // Expected byte at each position of dd:dd:dd,ddd.
  function automatic logic [BYTE_W-1:0] pat_char(input logic [POS_W-1:0] pos);
    logic [BYTE_W-1:0] c;
    case (pos)
      4'd2, 4'd5: c = CHAR_COLON;
      4'd8:       c = CHAR_COMMA;
      default:    c = ANY_DIGIT;
    endcase
    return c;
  endfunction

  // Millisecond weight of the digit at each position.
  function automatic logic [WEIGHT_W-1:0] pat_weight(input logic [POS_W-1:0] pos);
    logic [WEIGHT_W-1:0] w;
    case (pos)
      4'd0:    w = 26'd36000000;
      4'd1:    w = 26'd3600000;
      4'd3:    w = 26'd600000;
      4'd4:    w = 26'd60000;
      4'd6:    w = 26'd10000;
      4'd7:    w = 26'd1000;
      4'd9:    w = 26'd100;
      4'd10:   w = 26'd10;
      4'd11:   w = 26'd1;
      default: w = 26'd0;
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/core/srtp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtp_if: valid/ready channels of the subtitle time-range parser
// One interface for text bytes in, one for parsed line results out.
// ----------------------------------------------------------------------------
interface srtp_in_if;
  logic                       valid;
  logic                       ready;
  logic [srtp_pkg::BYTE_W-1:0] text_byte;
  logic                       line_end;

  modport source (output valid, output text_byte, output line_end, input ready);
  modport sink   (input valid, input text_byte, input line_end, output ready);
endinterface

interface srtp_out_if;
  logic                     valid;
  logic                     ready;
  logic                     both_found;
  logic                     first_found;
  logic [srtp_pkg::MS_W-1:0] start_ms;
  logic [srtp_pkg::MS_W-1:0] end_ms;

  modport source (output valid, output both_found, output first_found,
                  output start_ms, output end_ms, input ready);
  modport sink   (input valid, input both_found, input first_found,
                  input start_ms, input end_ms, output ready);
endinterface

FILE: rtl/core/srtp_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtp_scan: timestamp matcher and millisecond accumulator
// Steps one byte through the pattern per cycle in which step is high and forms the line result.
// ----------------------------------------------------------------------------
module srtp_scan (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic [srtp_pkg::BYTE_W-1:0]  text_byte,
  input  logic                         line_end,
  output srtp_pkg::result_t            result
);
  import srtp_pkg::*;

  logic [POS_W-1:0]   pos, pos_next;
  logic [COUNT_W-1:0] match_cnt, match_cnt_next;
  logic [MS_W-1:0]    running, running_next;
  logic [MS_W-1:0]    start_time, start_next;
  logic [MS_W-1:0]    end_time, end_next;

  logic [POS_W-1:0]   pos_eff;
  logic [MS_W-1:0]    running_eff;
  logic [BYTE_W-1:0]  want;
  logic               is_digit;
  logic               hit;
  logic [MS_W:0]      prod;
  logic [MS_W:0]      sum;
  logic [MS_W-1:0]    add;

  always_comb begin
    pos_eff     = (pos >= PATTERN_LEN) ? '0 : pos;
    running_eff = (pos_eff == '0) ? '0 : running;
    want        = pat_char(pos_eff);
    is_digit    = (text_byte >= CHAR_ZERO) && (text_byte <= CHAR_NINE);
    hit         = (want == ANY_DIGIT) ? is_digit : (text_byte == want);
    prod        = (MS_W+1)'(text_byte[DIGIT_W-1:0]) * (MS_W+1)'(pat_weight(pos_eff));
    add         = (hit && want == ANY_DIGIT) ? prod[MS_W-1:0] : '0;
    sum         = (MS_W+1)'(running_eff) + (MS_W+1)'(add);

    pos_next       = pos;
    match_cnt_next = match_cnt;
    running_next   = running;
    start_next     = start_time;
    end_next       = end_time;

    if (match_cnt < MATCH_BOTH) begin
      if (!hit) begin
        pos_next     = '0;
        running_next = '0;
      end else if (pos_eff == POS_LAST) begin
        if (match_cnt == MATCH_NONE) begin
          start_next = sum[MS_W-1:0];
        end else begin
          end_next = sum[MS_W-1:0];
        end
        match_cnt_next = match_cnt + 2'd1;
        pos_next       = '0;
        running_next   = '0;
      end else begin
        pos_next     = pos_eff + 4'd1;
        running_next = sum[MS_W-1:0];
      end
    end

    result.both_found  = (match_cnt_next >= MATCH_BOTH);
    result.first_found = (match_cnt_next >= MATCH_START);
    result.start_ms    = result.first_found ? start_next : '0;
    result.end_ms      = result.both_found ? end_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      match_cnt  <= '0;
      running    <= '0;
      start_time <= '0;
      end_time   <= '0;
    end else if (step) begin
      if (line_end) begin
        // drop all line state once the result is formed
        pos        <= '0;
        match_cnt  <= '0;
        running    <= '0;
        start_time <= '0;
        end_time   <= '0;
      end else begin
        pos        <= pos_next;
        match_cnt  <= match_cnt_next;
        running    <= running_next;
        start_time <= start_next;
        end_time   <= end_next;
      end
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst) pos < PATTERN_LEN)
    else $error("srtp_scan: pattern position out of range");

  a_match_cnt_range: assert property (@(posedge clk) disable iff (rst)
    match_cnt <= MATCH_BOTH)
    else $error("srtp_scan: match count above two");

  a_line_clear: assert property (@(posedge clk) disable iff (rst)
    step && line_end |=> (pos == '0) && (match_cnt == MATCH_NONE) && (running == '0))
    else $error("srtp_scan: state not cleared after end of line");

  a_done_frozen: assert property (@(posedge clk) disable iff (rst)
    step && !line_end && (match_cnt == MATCH_BOTH) |=> (match_cnt == MATCH_BOTH)
      && $stable(start_time) && $stable(end_time))
    else $error("srtp_scan: state changed after second match");

endmodule

FILE: rtl/core/subtitle_time_range_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subtitle_time_range_parser_top: subtitle line time-range parser
// Scans a byte stream for two dd:dd:dd,ddd timestamps per line.
// ----------------------------------------------------------------------------
// The parser takes one byte of a subtitle line per beat on the text channel
// and, on the beat flagged line_end, returns one beat on the result channel
// with the start and end times of the line in milliseconds. It sustains one
// byte per clock: a byte is registered on acceptance, scanned from that
// register by a single-pass matcher (one digit-times-weight product and one
// add), and the line result lands in an output register as its line_end byte
// is scanned. Only a line_end byte waits on the output register: text.ready
// drops for as long as a result is held unclaimed and a line_end byte is
// ready behind it; other bytes keep flowing.
// On a mismatch the matcher restarts at the first pattern position without
// rechecking the offending byte; bytes after the second timestamp are ignored.
// Fields are not range checked, so minutes of 99 simply add in.
// ----------------------------------------------------------------------------
module subtitle_time_range_parser_top (
  input  logic       clk,
  input  logic       rst,
  srtp_in_if.sink    text,
  srtp_out_if.source result
);
  import srtp_pkg::*;

  // input stage
  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              s1_end;
  logic              s1_fire;

  // output stage
  logic              o_valid;
  result_t           o_data;
  logic              out_free;

  result_t           scan_result;

  // A byte may leave the input stage unless it closes a line and the output
  // register still holds a result nobody has taken.
  assign out_free   = !o_valid || result.ready;
  assign s1_fire    = s1_valid && (!s1_end || out_free);
  assign text.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text.ready) begin
      s1_valid <= text.valid;
    end
  end

  // advance the payload with the beat; no reset needed
  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      s1_byte <= text.text_byte;
      s1_end  <= text.line_end;
    end
  end

  srtp_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_fire),
    .text_byte (s1_byte),
    .line_end  (s1_end),
    .result    (scan_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s1_fire && s1_end) begin
      o_valid <= 1'b1;
    end else if (result.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_end) begin
      o_data <= scan_result;
    end
  end

  assign result.valid       = o_valid;
  assign result.both_found  = o_data.both_found;
  assign result.first_found = o_data.first_found;
  assign result.start_ms    = o_data.start_ms;
  assign result.end_ms      = o_data.end_ms;

  a_hold_byte: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_fire |=> s1_valid && $stable(s1_byte) && $stable(s1_end))
    else $error("top: stalled byte lost or changed");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    o_valid && !result.ready |-> !(s1_fire && s1_end))
    else $error("top: pending result overwritten");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> (!o_data.both_found || o_data.first_found)
      && (o_data.first_found || (o_data.start_ms == '0))
      && (o_data.both_found || (o_data.end_ms == '0)))
    else $error("top: inconsistent result flags and times");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the subtitle time-range parser
// Feeds subtitle lines byte by byte over the text channel and checks every
// line result against a cycle-free model of the timestamp matcher. Lines mix
// well-formed dd:dd:dd,ddd stamps, broken stamps, arrows and raw noise, and
// the run steps through phases of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module tb_top;
  import srtp_pkg::*;

  typedef logic [BYTE_W-1:0] line_bytes_t[$];

  // Pattern slots that hold a literal separator; all others take a digit.
  localparam logic [POS_W-1:0] SLOT_HM_COLON  = 4'd2;
  localparam logic [POS_W-1:0] SLOT_MS_COLON  = 4'd5;
  localparam logic [POS_W-1:0] SLOT_FRAC_COMMA = 4'd8;

  // Millisecond weight of each pattern slot (separators weigh nothing).
  localparam logic [WEIGHT_W-1:0] SLOT_MS_WEIGHT [12] = '{
    26'd36000000, 26'd3600000, 26'd0, 26'd600000, 26'd60000, 26'd0,
    26'd10000, 26'd1000, 26'd0, 26'd100, 26'd10, 26'd1
  };

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int BEATS_PER_PHASE = 280;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_DASH  = 8'h2D;
  localparam logic [BYTE_W-1:0] CHAR_GT    = 8'h3E;

  logic clk = 1'b0;
  logic rst = 1'b1;

  srtp_in_if  text_ch ();
  srtp_out_if result_ch ();

  subtitle_time_range_parser_top uut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch.sink),
    .result (result_ch.source)
  );

  always #1 clk = ~clk;

  // Matcher state of the model, updated once per accepted text beat.
  logic [POS_W-1:0]   scan_pos;
  logic [COUNT_W-1:0] stamps_found;
  logic [MS_W-1:0]    stamp_acc_ms;
  logic [MS_W-1:0]    line_start_ms;
  logic [MS_W-1:0]    line_end_ms;

  // Line results still owed by the parser, oldest first.
  result_t pending_lines[$];

  int errors = 0;
  int beats_sent = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int quiet_cycles = 0;

  initial begin
    text_ch.valid     = 1'b0;
    text_ch.text_byte = '0;
    text_ch.line_end  = 1'b0;
    result_ch.ready   = 1'b1;
  end

  // --------------------------------------------------------------------------
  // Model: scan one byte, and on the line_end beat close out the line.
  // --------------------------------------------------------------------------
  task automatic clear_line_state();
    scan_pos      = '0;
    stamps_found  = MATCH_NONE;
    stamp_acc_ms  = '0;
    line_start_ms = '0;
    line_end_ms   = '0;
  endtask

  task automatic scan_text_byte(input logic [BYTE_W-1:0] b, input logic last);
    logic [POS_W-1:0]  slot;
    logic [BYTE_W-1:0] literal;
    logic              hit;
    logic [MS_W-1:0]   add_ms;
    result_t           line_res;
    add_ms = '0;
    // Once both stamps are in, the rest of the line is ignored.
    if (stamps_found < MATCH_BOTH) begin
      slot = (scan_pos >= PATTERN_LEN) ? '0 : scan_pos;
      if (slot == '0) stamp_acc_ms = '0;
      case (slot)
        SLOT_HM_COLON, SLOT_MS_COLON: literal = CHAR_COLON;
        SLOT_FRAC_COMMA:              literal = CHAR_COMMA;
        default:                      literal = ANY_DIGIT;
      endcase
      if (literal == ANY_DIGIT) begin
        hit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
        if (hit) add_ms = MS_W'((b - CHAR_ZERO) * SLOT_MS_WEIGHT[slot]);
      end else begin
        hit = (b == literal);
      end
      // A mismatch restarts at slot zero; the offending byte is not retried.
      if (!hit) begin
        scan_pos     = '0;
        stamp_acc_ms = '0;
      end else begin
        stamp_acc_ms = stamp_acc_ms + add_ms;
        if (slot == POS_LAST) begin
          if (stamps_found == MATCH_NONE) line_start_ms = stamp_acc_ms;
          else line_end_ms = stamp_acc_ms;
          stamps_found = stamps_found + 1'b1;
          scan_pos     = '0;
          stamp_acc_ms = '0;
        end else begin
          scan_pos = slot + 1'b1;
        end
      end
    end
    if (last) begin
      line_res.both_found  = (stamps_found >= MATCH_BOTH);
      line_res.first_found = (stamps_found >= MATCH_START);
      line_res.start_ms    = (stamps_found >= MATCH_START) ? line_start_ms : '0;
      line_res.end_ms      = (stamps_found >= MATCH_BOTH) ? line_end_ms : '0;
      pending_lines.insert(pending_lines.size(), line_res);
      clear_line_state();
    end
  endtask

  // --------------------------------------------------------------------------
  // Text side: one beat per call, with a random gap in front of it.
  // Drive on the falling edge, sample ready on the rising edge.
  // --------------------------------------------------------------------------
  task automatic send_beat(input logic [BYTE_W-1:0] b, input logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      text_ch.text_byte = BYTE_W'($urandom_range(255));
      @(negedge clk);
    end
    text_ch.valid     = 1'b1;
    text_ch.text_byte = b;
    text_ch.line_end  = last;
    @(posedge clk);
    while (!text_ch.ready) @(posedge clk);
    scan_text_byte(b, last);
    beats_sent++;
    @(negedge clk);
    text_ch.valid = 1'b0;
  endtask

  task automatic send_line(input line_bytes_t line);
    foreach (line[i]) send_beat(line[i], i == line.size() - 1);
  endtask

  task automatic send_string(input string s, input logic close_line);
    for (int i = 0; i < s.len(); i++)
      send_beat(s[i], close_line && (i == s.len() - 1));
  endtask

  // Hold until every line result has come back.
  task automatic drain_results();
    while (pending_lines.size() != 0) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Line generator: stamps lean toward the digits 0 and 9 so the largest and
  // smallest totals come up often.
  // --------------------------------------------------------------------------
  function automatic logic [BYTE_W-1:0] pick_digit();
    case ($urandom_range(9))
      0:       return CHAR_ZERO;
      1:       return CHAR_NINE;
      default: return CHAR_ZERO + BYTE_W'($urandom_range(9));
    endcase
  endfunction

  function automatic line_bytes_t make_stamp();
    line_bytes_t s;
    for (int i = 0; i < int'(PATTERN_LEN); i++) begin
      if (i == SLOT_HM_COLON || i == SLOT_MS_COLON) s.insert(s.size(), CHAR_COLON);
      else if (i == SLOT_FRAC_COMMA) s.insert(s.size(), CHAR_COMMA);
      else s.insert(s.size(), pick_digit());
    end
    return s;
  endfunction

  function automatic line_bytes_t make_line();
    line_bytes_t line;
    line_bytes_t seg;
    int          kind;
    // A bare one-byte line now and then.
    if ($urandom_range(99) < 8) begin
      line.insert(line.size(), BYTE_W'($urandom_range(255)));
      return line;
    end
    repeat ($urandom_range(1, 5)) begin
      kind = $urandom_range(99);
      if (kind < 45) begin
        seg = make_stamp();
      end else if (kind < 62) begin
        // Broken stamp: cut it short or corrupt one byte.
        seg = make_stamp();
        if ($urandom_range(1)) begin
          while (seg.size() > $urandom_range(1, 11)) void'(seg.pop_back());
        end else begin
          seg[$urandom_range(11)] = BYTE_W'($urandom_range(255));
        end
      end else if (kind < 78) begin
        seg = '{CHAR_SPACE, CHAR_DASH, CHAR_DASH, CHAR_GT, CHAR_SPACE};
      end else begin
        seg.delete();
        repeat ($urandom_range(1, 4)) seg.insert(seg.size(), BYTE_W'($urandom_range(255)));
      end
      line = {line, seg};
    end
    return line;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Largest stamp first, then the all-zero stamp, closed by its own last
  // digit, so line_end lands on the byte that completes the match.
  task automatic test_extreme_stamps();
    send_string("99:99:99,999", 1'b0);
    send_string("00:00:00,000", 1'b1);
    drain_results();
  endtask

  // "00:00" breaks on '1' where a colon belongs; '1' must not be retried as a
  // stamp start, so the "12:34:56,789" that follows never matches. A byte
  // with bit 7 set closes the line as a plain mismatch.
  task automatic test_mismatch_restart();
    send_string("00:0012:34:56,789", 1'b0);
    send_beat(8'hFF, 1'b1);
    drain_results();
  endtask

  // Random lines until the phase's share of beats has been sent.
  task automatic run_random_lines(input int idle_pct, input int stall_pct);
    int goal;
    goal = beats_sent + BEATS_PER_PHASE;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    while (beats_sent < goal) send_line(make_line());
    drain_results();
  endtask

  task automatic test_random_full_rate();
    run_random_lines(0, 0);
  endtask

  task automatic test_random_sender_gaps();
    run_random_lines(78, 0);
  endtask

  task automatic test_random_receiver_stalls();
    run_random_lines(0, 78);
  endtask

  task automatic test_random_both_idle();
    run_random_lines(24, 24);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: toggle ready at random on the falling edge.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    result_ch.ready = ($urandom_range(99) >= receiver_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Result check and watchdog, both on the rising edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if ((text_ch.valid && text_ch.ready) || (result_ch.valid && result_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (result_ch.valid && result_ch.ready) begin
        if (pending_lines.size() == 0) begin
          $display("%0t: unexpected result beat: both=%0b first=%0b start=%0d end=%0d",
                   $time, result_ch.both_found, result_ch.first_found,
                   result_ch.start_ms, result_ch.end_ms);
          errors++;
        end else begin
          want = pending_lines.pop_front();
          if (result_ch.both_found !== want.both_found) begin
            $display("%0t: both_found expected %0b actual %0b",
                     $time, want.both_found, result_ch.both_found);
            errors++;
          end
          if (result_ch.first_found !== want.first_found) begin
            $display("%0t: first_found expected %0b actual %0b",
                     $time, want.first_found, result_ch.first_found);
            errors++;
          end
          if (result_ch.start_ms !== want.start_ms) begin
            $display("%0t: start_ms expected %0d actual %0d",
                     $time, want.start_ms, result_ch.start_ms);
            errors++;
          end
          if (result_ch.end_ms !== want.end_ms) begin
            $display("%0t: end_ms expected %0d actual %0d",
                     $time, want.end_ms, result_ch.end_ms);
            errors++;
          end
        end
      end
      // Nothing moved on either channel for far too long: give up.
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d results outstanding",
                 $time, pending_lines.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, directed cases, then the four random phases.
  // --------------------------------------------------------------------------
  initial begin
    clear_line_state();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_extreme_stamps();
    test_mismatch_restart();
    test_random_full_rate();
    test_random_sender_gaps();
    test_random_receiver_stalls();
    test_random_both_idle();

    // Let any stray result beat show up before the verdict.
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/srtp_pkg.sv
rtl/core/srtp_if.sv
rtl/core/srtp_scan.sv
rtl/core/subtitle_time_range_parser_top.sv
tb/tb_top.sv
